/* src/ipsw_pkg.sv */
package ipsw_pkg;

    localparam int FRAC_BITS = 4;

    localparam logic [1:0] MODE_UPDATE    = 2'd0;
    localparam logic [1:0] MODE_CLR_ONE   = 2'd1;
    localparam logic [1:0] MODE_CLR_BOTH  = 2'd2;

    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_MAX_STEP  = 3'd3;
    localparam logic [2:0] REG_MAX_DRIVE = 3'd4;

    localparam logic [15:0] RST_GAIN_P    = 16'd640;
    localparam logic [15:0] RST_GAIN_I    = 16'd128;
    localparam logic [15:0] RST_GAIN_D    = 16'd13;
    localparam logic [15:0] RST_MAX_STEP  = 16'd160;
    localparam logic [15:0] RST_MAX_DRIVE = 16'd12800;

    localparam logic [11:0] DRIVE_MAX = 12'hFFF;

    typedef struct packed {
        logic [11:0] drive;
        logic        wheel;
        logic        last;
    } t_res;

    function automatic logic [11:0] drive_of(input logic [15:0] acc);
        logic [15:0] d;
        d = acc >> FRAC_BITS;
        if (d > {4'd0, DRIVE_MAX}) begin
            return DRIVE_MAX;
        end
        return d[11:0];
    endfunction

endpackage

/* src/incremental_pid_speed_two_wheel.sv */
// Channel   Dir  Handshake                      Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: target_rpm, measured_rpm
//                                                tuser: mode, wheel
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: drive; tuser: wheel_out;
//                                                tlast: last
// apb       in   psel/penable/pwrite/pready      gain_p, gain_i, gain_d, max_step,
//                                                max_drive at 4*i
//
// One item a cycle if the queue has room: the per-wheel PID update (three
// parallel multiplies, sum, clamps) is combinational off the input register.
// A clear-both item takes both slots of the two-beat result queue; the input
// stalls until the queue has room for the results of the held item.
// Reset is synchronous; history and accumulators clear at once.
// A stalled result side fills the queue within two beats, then input stalls.
module incremental_pid_speed_two_wheel
    import ipsw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] target_rpm, [31:16] measured_rpm
    input  logic [2:0]  i_s_axis_tuser,   // [1:0] mode, [2] wheel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [11:0] drive, [15:12] zero
    output logic [0:0]  o_m_axis_tuser,   // [0] wheel_out
    output logic        o_m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_gain_p, r_gain_i, r_gain_d, r_max_step, r_max_drive;

    logic               r_in_valid;
    logic [1:0]         r_in_mode;
    logic               r_in_wheel;
    logic signed [15:0] r_in_tgt;
    logic signed [15:0] r_in_meas;

    logic signed [16:0] r_e1 [2];
    logic signed [16:0] r_e2 [2];
    logic [15:0]        r_acc [2];

    t_res       r_q [2];
    t_res       n_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    logic               advance;
    logic               pop;
    logic [1:0]         need;
    logic signed [16:0] err;
    logic signed [16:0] e1;
    logic signed [16:0] e2;
    logic signed [17:0] dp;
    logic signed [18:0] dd;
    logic signed [16:0] gp, gi, gd;
    logic signed [34:0] prod_p;
    logic signed [33:0] prod_i;
    logic signed [35:0] prod_d;
    logic signed [29:0] delta_raw;
    logic signed [29:0] step30;
    logic signed [16:0] delta;
    logic signed [17:0] acc_sum;
    logic [15:0]        acc_new;
    t_res               res_a;
    t_res               res_b;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= RST_GAIN_P;
            r_gain_i    <= RST_GAIN_I;
            r_gain_d    <= RST_GAIN_D;
            r_max_step  <= RST_MAX_STEP;
            r_max_drive <= RST_MAX_DRIVE;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                REG_GAIN_P:    r_gain_p    <= pwdata[15:0];
                REG_GAIN_I:    r_gain_i    <= pwdata[15:0];
                REG_GAIN_D:    r_gain_d    <= pwdata[15:0];
                REG_MAX_STEP:  r_max_step  <= pwdata[15:0];
                REG_MAX_DRIVE: r_max_drive <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_GAIN_P:    prdata = {16'd0, r_gain_p};
            REG_GAIN_I:    prdata = {16'd0, r_gain_i};
            REG_GAIN_D:    prdata = {16'd0, r_gain_d};
            REG_MAX_STEP:  prdata = {16'd0, r_max_step};
            REG_MAX_DRIVE: prdata = {16'd0, r_max_drive};
            default:       prdata = 32'd0;
        endcase
    end

    // input register
    always_comb begin
        unique case (r_in_mode)
            MODE_UPDATE:   need = 2'd1;
            MODE_CLR_ONE:  need = 2'd1;
            MODE_CLR_BOTH: need = 2'd2;
            default:       need = 2'd0;
        endcase
    end

    assign advance         = r_in_valid && ({1'b0, r_cnt} + {1'b0, need} <= 3'd2);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_mode  <= i_s_axis_tuser[1:0];
            r_in_wheel <= i_s_axis_tuser[2];
            r_in_tgt   <= i_s_axis_tdata[15:0];
            r_in_meas  <= i_s_axis_tdata[31:16];
        end
    end

    // PID update
    assign err = 17'(r_in_tgt) - 17'(r_in_meas);
    assign e1  = r_e1[r_in_wheel];
    assign e2  = r_e2[r_in_wheel];
    assign dp  = 18'(err) - 18'(e1);
    assign dd  = 19'(err) - (19'(e1) <<< 1) + 19'(e2);
    assign gp  = $signed({1'b0, r_gain_p});
    assign gi  = $signed({1'b0, r_gain_i});
    assign gd  = $signed({1'b0, r_gain_d});

    assign prod_p = dp * gp;
    assign prod_i = err * gi;
    assign prod_d = dd * gd;

    assign delta_raw = 30'($signed(prod_p[34:8])) + 30'($signed(prod_i[33:8]))
                     + 30'($signed(prod_d[35:8]));
    assign step30    = $signed({14'd0, r_max_step});

    always_comb begin
        priority if (delta_raw > step30) begin
            delta = 17'(step30);
        end else if (delta_raw < -step30) begin
            delta = 17'(-step30);
        end else begin
            delta = 17'(delta_raw);
        end
    end

    assign acc_sum = $signed({2'b00, r_acc[r_in_wheel]}) + 18'(delta);

    always_comb begin
        priority if (acc_sum > $signed({2'b00, r_max_drive})) begin
            acc_new = r_max_drive;
        end else if (acc_sum < 18'sd0) begin
            acc_new = 16'd0;
        end else begin
            acc_new = acc_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_e1[i]  <= '0;
                r_e2[i]  <= '0;
                r_acc[i] <= '0;
            end
        end else if (advance) begin
            unique case (r_in_mode)
                MODE_UPDATE: begin
                    r_e2[r_in_wheel]  <= e1;
                    r_e1[r_in_wheel]  <= err;
                    r_acc[r_in_wheel] <= acc_new;
                end
                MODE_CLR_ONE: begin
                    r_e2[r_in_wheel]  <= '0;
                    r_e1[r_in_wheel]  <= '0;
                    r_acc[r_in_wheel] <= '0;
                end
                MODE_CLR_BOTH: begin
                    for (int i = 0; i < 2; i++) begin
                        r_e1[i]  <= '0;
                        r_e2[i]  <= '0;
                        r_acc[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result queue
    always_comb begin
        res_a.drive = (r_in_mode == MODE_UPDATE) ? drive_of(acc_new) : 12'd0;
        res_a.wheel = (r_in_mode == MODE_CLR_BOTH) ? 1'b0 : r_in_wheel;
        res_a.last  = (r_in_mode != MODE_CLR_BOTH);
        res_b.drive = 12'd0;
        res_b.wheel = 1'b1;
        res_b.last  = 1'b1;
    end

    assign pop = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 2'd1;
        end
        if (advance) begin
            unique case (need)
                2'd1: begin
                    n_q[n_cnt[0]] = res_a;
                    n_cnt         = n_cnt + 2'd1;
                end
                2'd2: begin
                    n_q[0] = res_a;
                    n_q[1] = res_b;
                    n_cnt  = 2'd2;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_m_axis_tvalid   = (r_cnt != 2'd0);
    assign o_m_axis_tdata    = {4'd0, r_q[0].drive};
    assign o_m_axis_tuser[0] = r_q[0].wheel;
    assign o_m_axis_tlast    = r_q[0].last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("result queue overfilled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_mode == MODE_CLR_BOTH |=>
        r_acc[0] == 16'd0 && r_acc[1] == 16'd0 && r_e1[0] == 17'sd0 && r_e1[1] == 17'sd0)
        else $error("clear of both wheels left state behind");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_mode == MODE_UPDATE |=>
        r_e1[$past(r_in_wheel)] == $past(err) && r_e2[$past(r_in_wheel)] == $past(e1))
        else $error("error history not advanced");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 && !r_q[0].last |-> r_cnt == 2'd2 && r_q[1].last)
        else $error("non-final beat without its final beat queued");

endmodule
